// File: design/ptb_pkg.sv
// Package for the periodic timer bank: sizes, opcodes, request/response
// payload structs and the slot entry layout. No dependencies.
package ptb_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 16;
  localparam int PERIOD_BITS = 32;
  localparam int SLOT_BITS   = 4;
  localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int CMP_W       = (TIME_BITS > PERIOD_BITS) ? TIME_BITS : PERIOD_BITS;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POLL   = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [SLOT_BITS-1:0]   slot;
    logic [PERIOD_BITS-1:0] period;
    logic                   repeat_flag;
    logic                   run_now_flag;
    logic                   auto_delete_flag;
    logic [TIME_BITS-1:0]   now_time;
  } req_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] fired_slot;
    logic                 fired;
    logic                 last;
  } rsp_t;

  typedef struct packed {
    logic auto_del;
    logic run_now;
    logic rep;
  } modes_t;

  typedef struct packed {
    logic [PERIOD_BITS-1:0] period;
    logic [TIME_BITS-1:0]   expiry;
    modes_t                 modes;
    logic                   called;
  } entry_t;

  // Outcome of one slot visit, handed from the expiry stages to the sequencer.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             emit;
    logic             kill;
    entry_t           wr;
  } dec_t;

endpackage

// File: design/ptb_slot_ram.sv
// Slot entry memory: one write port, one registered read port.
// Depends on ptb_pkg for the entry layout and depth.
module ptb_slot_ram
  import ptb_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ptb_expiry.sv
// Expiry check for one slot entry over two stages: sums and differences are
// registered, then compares pick the re-armed expiry and the fire decision.
// Depends on ptb_pkg.
module ptb_expiry
  import ptb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic [IDX_W-1:0]     in_idx,
  input  logic                 in_last,
  input  entry_t               rd,
  input  logic [TIME_BITS-1:0] now,
  output dec_t                 dec
);

  logic [TIME_BITS-1:0] pe;
  logic                 vld2;
  logic [IDX_W-1:0]     idx2;
  logic                 last2;
  logic [TIME_BITS-1:0] nxt, nxt2, ep, dold, dneg, expiry;
  logic [PERIOD_BITS-1:0] prd;
  logic                 zero;
  modes_t               modes;
  logic                 called;

  logic                 wrap, arm, expired, late, once, fire;
  logic [TIME_BITS-1:0] dsel, new_exp;

  assign pe = TIME_BITS'(rd.period);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (adv) begin
      vld2 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx2   <= in_idx;
      last2  <= in_last;
      nxt    <= now + pe;
      nxt2   <= now + TIME_BITS'({rd.period, 1'b0});
      ep     <= rd.expiry + pe;
      dold   <= now - rd.expiry;
      dneg   <= TIME_BITS'(0) - pe;
      expiry <= rd.expiry;
      prd    <= rd.period;
      zero   <= rd.expiry == '0;
      modes  <= rd.modes;
      called <= rd.called;
    end
  end

  always_comb begin
    // wrap reset and first-poll arming both restart from now + period
    wrap    = nxt < expiry;
    arm     = zero || wrap;
    expired = arm ? (nxt <= now) : (expiry <= now);
    dsel    = arm ? dneg : dold;
    late    = CMP_W'(dsel) > CMP_W'(prd);
    if (!expired) begin
      new_exp = arm ? nxt : expiry;
    end else if (late) begin
      new_exp = nxt;
    end else begin
      new_exp = arm ? nxt2 : ep;
    end
    once = zero && modes.run_now && !called;
    fire = once || expired;

    dec.valid     = vld2;
    dec.idx       = idx2;
    dec.last      = last2;
    dec.emit      = fire && (modes.rep || !called);
    dec.kill      = fire && !modes.rep && modes.auto_del;
    dec.wr.period = prd;
    dec.wr.expiry = new_exp;
    dec.wr.modes  = modes;
    dec.wr.called = called || fire;
  end

endmodule

// File: design/ptb_result.sv
// Response side: holds the newest fire until the next one (or the end of the
// poll) tells whether it is the last, and drives the response register.
// Depends on ptb_pkg.
module ptb_result
  import ptb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 hit,
  input  logic [SLOT_BITS-1:0] hit_slot,
  input  logic                 fin,
  input  logic                 rsp_ready,
  output logic                 rsp_valid,
  output rsp_t                 rsp_data,
  output logic                 can_push,
  output logic                 pend_valid,
  output logic                 cap_ok
);

  logic [SLOT_BITS-1:0] pend_slot;
  logic [CNT_W-1:0]     cnt;

  assign can_push = !rsp_valid || rsp_ready;
  assign cap_ok   = 32'(cnt) < 32'(MAX_RESULTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (fin) begin
        rsp_valid  <= 1'b1;
        pend_valid <= 1'b0;
        cnt        <= '0;
      end else if (hit && pend_valid) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (hit) begin
        pend_valid <= 1'b1;
        cnt        <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      // close the poll: flush the held fire, or report an empty poll
      if (pend_valid) begin
        rsp_data <= '{fired_slot: pend_slot, fired: 1'b1, last: 1'b1};
      end else begin
        rsp_data <= '{fired_slot: '0, fired: 1'b0, last: 1'b1};
      end
    end else if (hit && pend_valid) begin
      rsp_data <= '{fired_slot: pend_slot, fired: 1'b1, last: 1'b0};
    end
    if (hit) begin
      pend_slot <= hit_slot;
    end
  end

endmodule

// File: design/periodic_timer_bank.sv
// Channel   Direction  Payload  Handshake
// request   in         req_t    req_valid / req_ready
// response  out        rsp_t    rsp_valid / rsp_ready
//
// Add and remove requests write their slot when accepted. In a poll the slot
// memory's single read port visits one slot per cycle unless the scan is held,
// two expiry stages follow, and a closing state sends the final response.
// Reset frees every slot; slot entries need no clearing pass.
// A full response register stalls the scan only when a second fire arrives.
// Depends on ptb_pkg, ptb_slot_ram, ptb_expiry and ptb_result.
module periodic_timer_bank
  import ptb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t               state, state_next;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [TIME_BITS-1:0] poll_time;
  logic [IDX_W-1:0]     rd_idx;
  logic                 issue_on;
  logic                 vld1;
  logic [IDX_W-1:0]     idx1;
  logic                 last1;

  entry_t           rd_entry;
  dec_t             dec;
  logic             req_acc, slot_ok, dec_live, hit, adv, fin, re;
  logic             can_push, pend_valid, cap_ok;
  logic             we;
  logic [IDX_W-1:0] waddr, req_idx;
  entry_t           wdata;

  assign req_ready = state == ST_IDLE;
  assign req_acc   = req_valid && req_ready;
  assign req_idx   = IDX_W'(req_data.slot);
  assign slot_ok   = 32'(req_data.slot) < 32'(NUM_SLOTS);
  assign dec_live  = dec.valid && slot_valid[dec.idx];
  assign hit       = dec_live && dec.emit && cap_ok;
  // hold the scan while a held fire cannot move into the response register
  assign adv       = !(hit && pend_valid && !can_push);
  assign fin       = (state == ST_FIN) && can_push;
  assign re        = adv && issue_on;

  always_comb begin
    we    = 1'b0;
    waddr = dec.idx;
    wdata = dec.wr;
    if (req_acc && req_data.opcode == OP_ADD && slot_ok) begin
      we    = 1'b1;
      waddr = req_idx;
      wdata = '{period: req_data.period,
                expiry: '0,
                modes:  '{auto_del: req_data.auto_delete_flag,
                          run_now:  req_data.run_now_flag,
                          rep:      req_data.repeat_flag},
                called: 1'b0};
    end else if (adv && dec_live) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_acc && req_data.opcode == OP_POLL) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv && dec.valid && dec.last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slot_valid <= '0;
      issue_on   <= 1'b0;
      vld1       <= 1'b0;
    end else begin
      state <= state_next;
      if (req_acc && slot_ok) begin
        if (req_data.opcode == OP_ADD) begin
          slot_valid[req_idx] <= 1'b1;
        end else if (req_data.opcode == OP_REMOVE) begin
          slot_valid[req_idx] <= 1'b0;
        end
      end
      // drop a one-shot auto-delete slot once it has fired
      if (adv && dec_live && dec.kill) begin
        slot_valid[dec.idx] <= 1'b0;
      end
      if (req_acc && req_data.opcode == OP_POLL) begin
        issue_on <= 1'b1;
      end else if (re && rd_idx == LAST_IDX) begin
        issue_on <= 1'b0;
      end
      if (adv) begin
        vld1 <= issue_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc && req_data.opcode == OP_POLL) begin
      poll_time <= req_data.now_time;
      rd_idx    <= '0;
    end else if (re) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
    if (adv) begin
      idx1  <= rd_idx;
      last1 <= rd_idx == LAST_IDX;
    end
  end

  ptb_slot_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (rd_idx),
    .rdata (rd_entry)
  );

  ptb_expiry u_expiry (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (vld1),
    .in_idx  (idx1),
    .in_last (last1),
    .rd      (rd_entry),
    .now     (poll_time),
    .dec     (dec)
  );

  ptb_result u_result (
    .clk        (clk),
    .rst        (rst),
    .hit        (hit && adv),
    .hit_slot   (SLOT_BITS'(dec.idx)),
    .fin        (fin),
    .rsp_ready  (rsp_ready),
    .rsp_valid  (rsp_valid),
    .rsp_data   (rsp_data),
    .can_push   (can_push),
    .pend_valid (pend_valid),
    .cap_ok     (cap_ok)
  );

endmodule

// File: design/ptb_assert.sv
// Port-level checks for the periodic timer bank, bound to the top level.
// Depends on ptb_pkg and periodic_timer_bank.
module ptb_assert
  import ptb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req_data,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("response changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.fired |-> rsp_data.last && rsp_data.fired_slot == '0)
    else $error("empty poll response not final or slot nonzero");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.fired |-> 32'(rsp_data.fired_slot) < 32'(NUM_SLOTS))
    else $error("fired slot out of range");

  a_poll_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_data.opcode == OP_POLL |=> !req_ready)
    else $error("request taken during a poll scan");

endmodule

bind periodic_timer_bank ptb_assert u_ptb_assert (.*);

// File: dv/tb.sv
// Self-checking testbench for periodic_timer_bank: a scoreboard class predicts
// fire responses per request, plain tasks and a receiver process drive the valid/ready channels.
// Depends on ptb_pkg and the periodic_timer_bank RTL.
module tb
  import ptb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         SETTLE      = 4 * (NUM_SLOTS + 4);
  localparam int         HOLD_CYCLES = 400;
  localparam int         PHASE_ITEMS = 44;

  class timer_scoreboard;
    bit [NUM_SLOTS-1:0]     armed_slots;
    logic [PERIOD_BITS-1:0] period [NUM_SLOTS];
    logic [TIME_BITS-1:0]   expiry [NUM_SLOTS];
    modes_t                 modes [NUM_SLOTS];
    bit                     called [NUM_SLOTS];
    rsp_t                   pending [$];
    int                     errors;

    function new();
      armed_slots = '0;
      errors = 0;
    endfunction

    // Check one slot's expiry against now and re-arm it; 1 when it expired.
    function bit expire_and_rearm(int i, logic [TIME_BITS-1:0] now);
      logic [TIME_BITS-1:0] prd;
      logic [TIME_BITS-1:0] nxt;
      logic [TIME_BITS-1:0] late;
      prd = TIME_BITS'(period[i]);
      nxt = now + prd;
      if (nxt < expiry[i]) expiry[i] = '0;
      if (expiry[i] == '0) expiry[i] = nxt;
      if (expiry[i] > now) return 1'b0;
      late = now - expiry[i];
      // catch up in one step when more than a period behind
      if (late > prd) expiry[i] = nxt;
      else expiry[i] = expiry[i] + prd;
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      int   n;
      bit   once;
      bit   hit;
      rsp_t e;
      n = 0;
      case (r.opcode)
        OP_ADD: begin
          if (r.slot < NUM_SLOTS) begin
            armed_slots[r.slot] = 1'b1;
            period[r.slot] = r.period;
            expiry[r.slot] = '0;
            modes[r.slot].rep = r.repeat_flag;
            modes[r.slot].run_now = r.run_now_flag;
            modes[r.slot].auto_del = r.auto_delete_flag;
            called[r.slot] = 1'b0;
          end
        end
        OP_REMOVE: begin
          if (r.slot < NUM_SLOTS) armed_slots[r.slot] = 1'b0;
        end
        OP_POLL: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (armed_slots[i]) begin
              once = (expiry[i] == '0) && modes[i].run_now && !called[i];
              hit = expire_and_rearm(i, r.now_time);
              if (once || hit) begin
                if ((modes[i].rep || !called[i]) && n < MAX_RESULTS) begin
                  e.fired_slot = SLOT_BITS'(i);
                  e.fired = 1'b1;
                  e.last = 1'b0;
                  pending.push_back(e);
                  n++;
                end
                called[i] = 1'b1;
                if (!modes[i].rep && modes[i].auto_del) armed_slots[i] = 1'b0;
              end
            end
          end
          if (n == 0) begin
            e = '0;
            e.last = 1'b1;
            pending.push_back(e);
          end else begin
            // mark the final fire of this poll
            e = pending.pop_back();
            e.last = 1'b1;
            pending.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $error("unexpected response: fired_slot %0d fired %0d last %0d",
               got.fired_slot, got.fired, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.fired_slot !== want.fired_slot) begin
        $error("fired_slot: expected %0d, actual %0d", want.fired_slot, got.fired_slot);
        errors++;
      end
      if (got.fired !== want.fired) begin
        $error("fired: expected %0d, actual %0d", want.fired, got.fired);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  timer_scoreboard      sb;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   hold_cnt = 0;
  int                   cycles = 0;
  logic [TIME_BITS-1:0] sim_now = '0;

  periodic_timer_bank u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp_data);
  end

  // Receiver: a long hold-off first if one is pending, then random stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic req_t noise_request();
    req_t r;
    r.opcode = 2'($urandom);
    r.slot = SLOT_BITS'($urandom);
    r.period = $urandom;
    r.repeat_flag = 1'($urandom);
    r.run_now_flag = 1'($urandom);
    r.auto_delete_flag = 1'($urandom);
    r.now_time = TIME_BITS'({$urandom, $urandom});
    return r;
  endfunction

  function automatic req_t add_request(int slot, logic [PERIOD_BITS-1:0] prd,
                                       bit rep, bit run_now, bit auto_del);
    req_t r;
    r = noise_request();
    r.opcode = OP_ADD;
    r.slot = SLOT_BITS'(slot);
    r.period = prd;
    r.repeat_flag = rep;
    r.run_now_flag = run_now;
    r.auto_delete_flag = auto_del;
    return r;
  endfunction

  function automatic req_t remove_request(int slot);
    req_t r;
    r = noise_request();
    r.opcode = OP_REMOVE;
    r.slot = SLOT_BITS'(slot);
    return r;
  endfunction

  function automatic req_t poll_request(logic [TIME_BITS-1:0] now);
    req_t r;
    r = noise_request();
    r.opcode = OP_POLL;
    r.now_time = now;
    return r;
  endfunction

  // Mostly adds and forward-moving polls; some removes, time jumps and junk.
  function automatic req_t random_request();
    int                     k;
    logic [PERIOD_BITS-1:0] prd;
    req_t                   r;
    k = $urandom_range(99);
    if (k < 5) begin
      r = noise_request();
      r.opcode = OP_UNUSED;
    end else if (k < 40) begin
      k = $urandom_range(99);
      if (k < 10) prd = '0;
      else if (k < 20) prd = $urandom;
      else if (k < 30) prd = $urandom_range(1, 5);
      else prd = $urandom_range(1, 200);
      r = add_request($urandom_range(NUM_SLOTS - 1), prd, 1'($urandom),
                      1'($urandom), 1'($urandom));
    end else if (k < 52) begin
      r = remove_request($urandom_range(NUM_SLOTS - 1));
    end else begin
      k = $urandom_range(99);
      if (k < 5) sim_now = sim_now - TIME_BITS'($urandom_range(500));
      else if (k < 10) sim_now = TIME_BITS'({$urandom, $urandom});
      else if (k >= 20) sim_now = sim_now + TIME_BITS'($urandom_range(150));
      r = poll_request(sim_now);
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  task automatic run_phase(int items, int send_pct, int recv_pct);
    int   done;
    req_t r;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    done = 0;
    while (done < items) begin
      r = random_request();
      send_request(r);
      if (r.opcode != OP_UNUSED) done++;
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty poll, flag mixes, period extremes, wrap and catch-up
    send_request(poll_request('0));
    send_request(add_request(0, 32'd10, 1'b0, 1'b1, 1'b0));
    send_request(add_request(15, '1, 1'b1, 1'b0, 1'b1));
    send_request(add_request(5, '0, 1'b1, 1'b1, 1'b1));
    send_request(add_request(7, 32'd3, 1'b0, 1'b0, 1'b1));
    send_request(add_request(9, 32'd4, 1'b0, 1'b0, 1'b0));
    send_request(poll_request(48'd100));
    send_request(poll_request(48'd100));
    send_request(poll_request(48'd105));
    send_request(poll_request(48'd200));
    send_request(poll_request(48'd50));
    send_request(remove_request(3));
    begin
      req_t junk;
      junk = noise_request();
      junk.opcode = OP_UNUSED;
      send_request(junk);
    end
    send_request(add_request(0, 32'd1, 1'b1, 1'b1, 1'b1));
    send_request(remove_request(15));
    send_request(poll_request('1));
    send_request(poll_request(48'd2));
    send_request(add_request(12, '1, 1'b0, 1'b1, 1'b1));
    send_request(poll_request(48'd3));
    send_request(remove_request(5));
    send_request(remove_request(0));
    send_request(poll_request(48'd10));
    sim_now = 48'd10;

    // hold the receiver off while every slot fires on each poll
    hold_cnt = HOLD_CYCLES;
    for (int i = 0; i < NUM_SLOTS; i++)
      send_request(add_request(i, 32'($urandom_range(1, 3)), 1'b1, 1'($urandom), 1'b0));
    repeat (8) begin
      sim_now = sim_now + 48'd10;
      send_request(poll_request(sim_now));
    end

    run_phase(PHASE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 49, 0);
    run_phase(PHASE_ITEMS, 0, 49);
    run_phase(PHASE_ITEMS, 21, 21);

    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
design/ptb_pkg.sv
design/ptb_slot_ram.sv
design/ptb_expiry.sv
design/ptb_result.sv
design/periodic_timer_bank.sv
design/ptb_assert.sv
dv/tb.sv
